FILE: hw/rtl/bldc_hall_commutator_unit_assert.svh
// assertion macros shared by the hall commutator rtl
`ifndef BLDC_HALL_COMMUTATOR_UNIT_ASSERT_SVH
`define BLDC_HALL_COMMUTATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BHC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHC_ASSERT(lbl, clk, rst, prop, msg)
`define BHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/bhc_pkg.sv
// types, constants and lookup functions of the hall commutator
package bhc_pkg;

   localparam int CMP_W = 16;
   localparam int PERIOD_W = 16;
   localparam int DUTY_W = 16;
   localparam int DEAD_W = 15;
   localparam int POS_W = 3;
   localparam int PH_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // wide enough for period+dead, 2*dead and any compare value, plus a carry
   localparam int SUM_W = 18;
   localparam int EXT_W = ((CMP_W > SUM_W) ? CMP_W : SUM_W) + 1;
   localparam logic [EXT_W-1:0] CMP_MAX = EXT_W'({CMP_W{1'b1}});

   localparam logic [CSR_IDX_W-1:0] REG_PWM_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_DUTY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_TIME = 2'd2;

   localparam logic [PH_W-1:0] PH_AC = 3'd0;
   localparam logic [PH_W-1:0] PH_BC = 3'd1;
   localparam logic [PH_W-1:0] PH_BA = 3'd2;
   localparam logic [PH_W-1:0] PH_CA = 3'd3;
   localparam logic [PH_W-1:0] PH_CB = 3'd4;
   localparam logic [PH_W-1:0] PH_AB = 3'd5;
   localparam logic [PH_W-1:0] PH_OFF = 3'd6;

   localparam logic [POS_W-1:0] POS_NONE = 3'd0;
   localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
   localparam logic [POS_W-1:0] POS_LAST = 3'd6;

   typedef struct packed {
      logic [PERIOD_W-1:0] pwm_period;
      logic [DUTY_W-1:0] pwm_duty;
      logic [DEAD_W-1:0] dead_time;
   } cfg_type;

   // last declared field sits in the lowest bits
   typedef struct packed {
      logic stop;
      logic direction;
      logic [POS_W-1:0] hall_pos;
   } req_type;

   typedef struct packed {
      logic seq_error;
      logic pos_error;
      logic low_c_on;
      logic low_b_on;
      logic low_a_on;
      logic [CMP_W-1:0] ch_c_secondary;
      logic [CMP_W-1:0] ch_c_primary;
      logic [CMP_W-1:0] ch_b_secondary;
      logic [CMP_W-1:0] ch_b_primary;
      logic [CMP_W-1:0] ch_a_secondary;
      logic [CMP_W-1:0] ch_a_primary;
      logic [PH_W-1:0] phase;
   } rsp_type;

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   function automatic logic [PH_W-1:0] phase_lookup(logic [POS_W-1:0] pos, logic fwd);
      logic [PH_W-1:0] ph;
      ph = PH_OFF;
      if (fwd) begin
         unique case (pos)
            3'd1: ph = PH_AB;
            3'd2: ph = PH_AC;
            3'd3: ph = PH_BC;
            3'd4: ph = PH_BA;
            3'd5: ph = PH_CA;
            3'd6: ph = PH_CB;
            default: ph = PH_OFF;
         endcase
      end else begin
         unique case (pos)
            3'd1: ph = PH_AC;
            3'd2: ph = PH_BC;
            3'd3: ph = PH_BA;
            3'd4: ph = PH_CA;
            3'd5: ph = PH_CB;
            3'd6: ph = PH_AB;
            default: ph = PH_OFF;
         endcase
      end
      return ph;
   endfunction

   function automatic logic [CMP_W-1:0] sat_cmp(logic [EXT_W-1:0] v);
      return (v > CMP_MAX) ? CMP_MAX[CMP_W-1:0] : v[CMP_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/bhc_csr.sv
// configuration registers of the hall commutator
module bhc_csr
   import bhc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PWM_PERIOD: cfg_in.pwm_period = PERIOD_W'(csr_data);
            REG_PWM_DUTY: cfg_in.pwm_duty = DUTY_W'(csr_data);
            REG_DEAD_TIME: cfg_in.dead_time = csr_data[DEAD_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/bhc_step.sv
// input register, commutation decode and hall/phase order tracking
`include "bldc_hall_commutator_unit_assert.svh"
module bhc_step
   import bhc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    res_valid,
   input  logic    res_ready,
   output rsp_type res
);

   logic            valid_ff, valid_in;
   req_type         item_ff;
   logic [POS_W-1:0] last_pos_ff, last_pos_in;
   logic [PH_W-1:0] last_ph_ff, last_ph_in;
   logic            advance;

   logic [PH_W-1:0] ph;
   logic            pos_ok;
   logic [POS_W-1:0] pos_expect;
   logic [PH_W-1:0] ph_expect;
   logic [SUM_W-1:0] dead2;
   logic [CMP_W-1:0] idle_p, drv_p, drv_s;

   assign advance = valid_ff && res_ready;
   assign in_ready = !valid_ff || res_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !res_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_pos_ff <= POS_NONE;
         last_ph_ff <= PH_OFF;
      end else begin
         valid_ff <= valid_in;
         last_pos_ff <= last_pos_in;
         last_ph_ff <= last_ph_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   // order state follows each item as it leaves, stop included
   assign last_pos_in = advance ? item_ff.hall_pos : last_pos_ff;
   assign last_ph_in = advance ? ph : last_ph_ff;

   assign ph = phase_lookup(item_ff.hall_pos, item_ff.direction);
   assign pos_ok = (item_ff.hall_pos >= POS_FIRST) && (item_ff.hall_pos <= POS_LAST);

   always_comb begin
      if (item_ff.direction) begin
         pos_expect = (item_ff.hall_pos == POS_FIRST) ? POS_LAST : item_ff.hall_pos - 3'd1;
         ph_expect = (ph == PH_AC) ? PH_AB : ph - 3'd1;
      end else begin
         pos_expect = (item_ff.hall_pos == POS_LAST) ? POS_FIRST : item_ff.hall_pos + 3'd1;
         ph_expect = (ph == PH_AB) ? PH_AC : ph + 3'd1;
      end
   end

   assign dead2 = SUM_W'({cfg.dead_time, 1'b0});
   assign idle_p = sat_cmp(EXT_W'(cfg.pwm_period) + EXT_W'(cfg.dead_time));
   assign drv_p = sat_cmp(EXT_W'(dead2));
   assign drv_s = (EXT_W'(cfg.pwm_duty) > EXT_W'(dead2)) ?
                  sat_cmp(EXT_W'(cfg.pwm_duty) - EXT_W'(dead2)) : '0;

   always_comb begin
      res = '0;
      res.ch_a_primary = idle_p;
      res.ch_b_primary = idle_p;
      res.ch_c_primary = idle_p;
      res.phase = PH_OFF;
      if (!item_ff.stop && ph != PH_OFF) begin
         res.phase = ph;
         unique case (ph)
            PH_AC: begin
               res.ch_a_primary = drv_p;
               res.ch_a_secondary = drv_s;
               res.low_a_on = 1'b1;
            end
            PH_AB: begin
               res.ch_a_primary = drv_p;
               res.ch_a_secondary = drv_s;
               res.low_c_on = 1'b1;
            end
            PH_BC: begin
               res.ch_b_primary = drv_p;
               res.ch_b_secondary = drv_s;
               res.low_a_on = 1'b1;
            end
            PH_BA: begin
               res.ch_b_primary = drv_p;
               res.ch_b_secondary = drv_s;
               res.low_b_on = 1'b1;
            end
            PH_CA: begin
               res.ch_c_primary = drv_p;
               res.ch_c_secondary = drv_s;
               res.low_b_on = 1'b1;
            end
            PH_CB: begin
               res.ch_c_primary = drv_p;
               res.ch_c_secondary = drv_s;
               res.low_c_on = 1'b1;
            end
            default: res.phase = PH_OFF;
         endcase
      end
      // order checks use the hall phase even under stop
      res.pos_error = !pos_ok || (last_pos_ff != pos_expect);
      res.seq_error = (ph == PH_OFF) || (last_ph_ff != ph_expect);
   end

   assign res_valid = valid_ff;

   `BHC_ASSERT(a_off_no_low, clock, reset,
      valid_ff && res.phase == PH_OFF |-> !(res.low_a_on || res.low_b_on || res.low_c_on),
      "low side enabled with phase off")
   `BHC_ASSERT(a_drive_one_low, clock, reset,
      valid_ff && res.phase != PH_OFF |-> $onehot({res.low_a_on, res.low_b_on, res.low_c_on}),
      "driven phase needs exactly one low side")
   `BHC_ASSERT(a_hold_item, clock, reset,
      valid_ff && !res_ready |=> valid_ff && $stable(item_ff) && $stable(last_ph_ff),
      "stalled item or order state changed")
   `BHC_ASSERT(a_invalid_pos_err, clock, reset,
      valid_ff && !pos_ok |-> res.pos_error && res.seq_error,
      "invalid hall position not flagged")

endmodule

FILE: hw/rtl/bhc_rsp.sv
// result register toward the output channel
`include "bldc_hall_commutator_unit_assert.svh"
module bhc_rsp
   import bhc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_item,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

   `BHC_ASSERT_ALWAYS(a_empty_after_reset, clock,
      reset |=> !valid_ff,
      "result valid right after reset")

endmodule

FILE: hw/rtl/bldc_hall_commutator_unit.sv
// six-step hall commutator top level
// pipeline: two register stages (input register, result register); rsp_tvalid rises
// when an accepted req moves on into the result register, which holds it until rsp_tready
// one item per cycle unless rsp_tready stalls; decode: one lookup plus saturating adds
// config registers reset to 0, hall order state to no position and phase off
// reset is synchronous, active high; no clearing pass
module bldc_hall_commutator_unit
   import bhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // hall_pos[2:0], direction[3], stop[4], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // phase, ch_a_primary, ch_a_secondary, ch_b_primary, ch_b_secondary,
   // ch_c_primary, ch_c_secondary, low_a_on, low_b_on, low_c_on, pos_error, seq_error
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;
   req_type req_item;
   rsp_type step_res, out_item;
   logic    step_valid, step_ready;

   assign req_item = req_tdata[REQ_W-1:0];

   bhc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bhc_step u_step (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .res_valid (step_valid),
      .res_ready (step_ready),
      .res       (step_res)
   );

   bhc_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_ready  (step_ready),
      .in_item   (step_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = RSP_TDATA_W'(out_item);

endmodule
